FILE: rtl/date_time_setting_editor_assert.svh
// Assertion macros for the date and time setting editor.
// Included by the top level; no other dependencies.
`ifndef DATE_TIME_SETTING_EDITOR_ASSERT_SVH
`define DATE_TIME_SETTING_EDITOR_ASSERT_SVH

// same-cycle implication
`define DTSE_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define DTSE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/dtse_pkg.sv
// Package for the date and time setting editor: word and state types,
// request codes, calendar helpers. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package dtse_pkg;

   typedef enum logic [2:0] {
      REQ_LOAD    = 3'd0,
      REQ_INC     = 3'd1,
      REQ_DEC     = 3'd2,
      REQ_LEFT    = 3'd3,
      REQ_RIGHT   = 3'd4,
      REQ_CONFIRM = 3'd5,
      REQ_CANCEL  = 3'd6
   } req_code_type;

   localparam logic [11:0] YEAR_MIN = 12'd1970;
   localparam logic [11:0] YEAR_MAX = 12'd2099;
   localparam logic [3:0] CURSOR_FIRST = 4'd1;
   localparam logic [3:0] CURSOR_LAST = 4'd14;
   // first digit position of each field
   localparam logic [3:0] POS_MONTH = 4'd5;
   localparam logic [3:0] POS_DAY = 4'd7;
   localparam logic [3:0] POS_HOUR = 4'd9;
   localparam logic [3:0] POS_MINUTE = 4'd11;
   localparam logic [3:0] POS_SECOND = 4'd13;

   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 48;

   typedef struct packed {
      logic [2:0]  req_type;
      logic [11:0] new_year;
      logic [3:0]  new_month;
      logic [4:0]  new_day;
      logic [4:0]  new_hour;
      logic [5:0]  new_minute;
      logic [5:0]  new_second;
   } req_word_type;

   typedef struct packed {
      logic [11:0] show_year;
      logic [3:0]  show_month;
      logic [4:0]  show_day;
      logic [4:0]  show_hour;
      logic [5:0]  show_minute;
      logic [5:0]  show_second;
      logic [3:0]  cursor_pos;
      logic        committed;
      logic        editing;
   } rsp_word_type;

   typedef struct packed {
      logic [11:0] year;
      logic [3:0]  month;
      logic [4:0]  day;
      logic [4:0]  hour;
      logic [5:0]  minute;
      logic [5:0]  second;
   } date_type;

   typedef struct packed {
      logic       edit_active;
      logic [3:0] cursor;
      date_type   staged;
      date_type   stored;
   } state_type;

   localparam date_type DATE_RESET = '{
      year: YEAR_MIN, month: 4'd1, day: 5'd1, hour: 5'd0, minute: 6'd0, second: 6'd0};

   // year % 100 == 0 for a multiple of 4: y/4 % 25 == 0, folded with 32 = 7 mod 25
   function automatic logic is_century(input logic [11:0] y);
      logic [7:0] t;
      logic       hit;
      t = ({y[11:7], 3'b000} - {3'b000, y[11:7]}) + {3'b000, y[6:2]};
      unique case (t)
         8'd0, 8'd25, 8'd50, 8'd75, 8'd100,
         8'd125, 8'd150, 8'd175, 8'd200, 8'd225: hit = 1'b1;
         default: hit = 1'b0;
      endcase
      return hit;
   endfunction

   function automatic logic is_leap(input logic [11:0] y);
      logic div4;
      div4 = (y[1:0] == 2'b00);
      return div4 && (!is_century(y) || (y[3:0] == 4'b0000));
   endfunction

   function automatic logic [4:0] month_length(input logic [11:0] y, input logic [3:0] m);
      logic [4:0] len;
      unique case (m)
         4'd2: len = is_leap(y) ? 5'd29 : 5'd28;
         4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
         default: len = 5'd31;
      endcase
      return len;
   endfunction

   // add, then wrap past either end to the opposite end
   function automatic logic [7:0] wrap_field(input logic [7:0] v, input logic signed [7:0] delta,
                                             input logic [7:0] lo, input logic [7:0] hi);
      logic signed [8:0] sum;
      logic [7:0]        res;
      sum = $signed({1'b0, v}) + 9'(delta);
      if (sum > $signed({1'b0, hi})) begin
         res = lo;
      end else if (sum < $signed({1'b0, lo})) begin
         res = hi;
      end else begin
         res = sum[7:0];
      end
      return res;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/dtse_update.sv
// Next-state and result logic for one request word.
// Depends on dtse_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dtse_update
   import dtse_pkg::*;
(
   input  state_type    cur_state,
   input  req_word_type word,
   output state_type    nxt_state,
   output rsp_word_type result
);

   logic                inc;
   logic                dec;
   logic [9:0]          year_step;
   logic signed [13:0]  year_sum;
   logic signed [7:0]   delta;
   logic [3:0]          cur;
   date_type            st;
   date_type            adj;
   date_type            shown;
   logic                did_commit;

   always_comb begin
      cur = cur_state.cursor;
      st = cur_state.staged;
      inc = (word.req_type == REQ_INC);
      dec = (word.req_type == REQ_DEC);

      unique case (cur[1:0])
         2'd1: year_step = 10'd1000;
         2'd2: year_step = 10'd100;
         2'd3: year_step = 10'd10;
         default: year_step = 10'd1;
      endcase
      year_sum = inc ? ($signed({2'b00, st.year}) + $signed({4'b0000, year_step}))
                     : ($signed({2'b00, st.year}) - $signed({4'b0000, year_step}));
      delta = cur[0] ? 8'sd10 : 8'sd1;
      if (dec) begin
         delta = -delta;
      end

      adj = st;
      priority if (cur < CURSOR_FIRST) begin
         adj = st;
      end else if (cur < POS_MONTH) begin
         adj.year = year_sum[11:0];
         if (inc && year_sum > $signed({2'b00, YEAR_MAX})) begin
            adj.year = YEAR_MAX;
         end
         if (dec && year_sum < $signed({2'b00, YEAR_MIN})) begin
            adj.year = YEAR_MIN;
         end
      end else if (cur < POS_DAY) begin
         adj.month = 4'(wrap_field({4'b0, st.month}, delta, 8'd1, 8'd12));
      end else if (cur < POS_HOUR) begin
         adj.day = 5'(wrap_field({3'b0, st.day}, delta, 8'd1,
                                 {3'b0, month_length(st.year, st.month)}));
      end else if (cur < POS_MINUTE) begin
         adj.hour = 5'(wrap_field({3'b0, st.hour}, delta, 8'd0, 8'd23));
      end else if (cur < POS_SECOND) begin
         adj.minute = 6'(wrap_field({2'b0, st.minute}, delta, 8'd0, 8'd59));
      end else if (cur <= CURSOR_LAST) begin
         adj.second = 6'(wrap_field({2'b0, st.second}, delta, 8'd0, 8'd59));
      end else begin
         adj = st;
      end

      nxt_state = cur_state;
      did_commit = 1'b0;
      if (word.req_type == REQ_LOAD) begin
         nxt_state.staged = '{year: word.new_year, month: word.new_month, day: word.new_day,
                              hour: word.new_hour, minute: word.new_minute,
                              second: word.new_second};
         nxt_state.cursor = CURSOR_FIRST;
         nxt_state.edit_active = 1'b1;
      end else if (cur_state.edit_active) begin
         unique case (word.req_type)
            REQ_INC, REQ_DEC: nxt_state.staged = adj;
            REQ_LEFT: nxt_state.cursor = (cur <= CURSOR_FIRST) ? CURSOR_LAST : cur - 4'd1;
            REQ_RIGHT: nxt_state.cursor = (cur >= CURSOR_LAST) ? CURSOR_FIRST : cur + 4'd1;
            REQ_CONFIRM: begin
               nxt_state.stored = st;
               nxt_state.edit_active = 1'b0;
               did_commit = 1'b1;
            end
            REQ_CANCEL: nxt_state.edit_active = 1'b0;
            default: nxt_state = cur_state;
         endcase
      end

      shown = nxt_state.edit_active ? nxt_state.staged : nxt_state.stored;
      result.show_year = shown.year;
      result.show_month = shown.month;
      result.show_day = shown.day;
      result.show_hour = shown.hour;
      result.show_minute = shown.minute;
      result.show_second = shown.second;
      result.cursor_pos = nxt_state.edit_active ? nxt_state.cursor : 4'd0;
      result.committed = did_commit;
      result.editing = nxt_state.edit_active;
   end

endmodule

`default_nettype wire

FILE: rtl/date_time_setting_editor.sv
// Request words pass through the input register, then the result register.
// Throughput: one word per cycle unless the result side stalls; one pass through dtse_update.
// Reset (synchronous, active high): no session open, cursor 1, staged and committed
// date 1970-01-01 00:00:00, both registers empty.
// Top level of the date and time setting editor; uses dtse_pkg, dtse_update
// and date_time_setting_editor_assert.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "date_time_setting_editor_assert.svh"

module date_time_setting_editor
   import dtse_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // new_year, new_month, new_day, new_hour, new_minute, new_second, zero pad
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   // req_type
   input  wire logic [2:0]            req_tuser,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // show_year, show_month, show_day, show_hour, show_minute, show_second,
   // cursor_pos, zero pad
   output logic [RSP_DATA_W-1:0]      rsp_tdata,
   // committed, editing
   output logic [1:0]                 rsp_tuser
);

   logic         in_valid_ff;
   req_word_type in_word_ff;
   req_word_type in_word_in;
   logic         rsp_valid_ff;
   rsp_word_type rsp_word_ff;
   rsp_word_type rsp_word_in;
   state_type    state_ff;
   state_type    state_in;
   logic         advance;
   logic         take;

   assign advance = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign take = req_tvalid && req_tready;

   assign in_word_in = '{req_type: req_tuser,
                         new_year: req_tdata[11:0], new_month: req_tdata[15:12],
                         new_day: req_tdata[20:16], new_hour: req_tdata[25:21],
                         new_minute: req_tdata[31:26], new_second: req_tdata[37:32]};

   dtse_update u_update (
      .cur_state (state_ff),
      .word      (in_word_ff),
      .nxt_state (state_in),
      .result    (rsp_word_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff <= '{edit_active: 1'b0, cursor: CURSOR_FIRST,
                       staged: DATE_RESET, stored: DATE_RESET};
      end else begin
         if (req_tready) begin
            in_valid_ff <= req_tvalid;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
            state_ff <= state_in;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         in_word_ff <= in_word_in;
      end
      if (advance) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = {6'b000000, rsp_word_ff.cursor_pos, rsp_word_ff.show_second,
                       rsp_word_ff.show_minute, rsp_word_ff.show_hour, rsp_word_ff.show_day,
                       rsp_word_ff.show_month, rsp_word_ff.show_year};
   assign rsp_tuser = {rsp_word_ff.editing, rsp_word_ff.committed};

   `DTSE_ASSERT_NOW(a_cursor_range, clock, reset, 1'b1,
      state_ff.cursor >= CURSOR_FIRST && state_ff.cursor <= CURSOR_LAST,
      "cursor left the digit range")
   `DTSE_ASSERT_NOW(a_idle_cursor, clock, reset, rsp_valid_ff && !rsp_word_ff.editing,
      rsp_word_ff.cursor_pos == 4'd0, "idle result carries a cursor")
   `DTSE_ASSERT_NOW(a_commit_closes, clock, reset, rsp_valid_ff && rsp_word_ff.committed,
      !rsp_word_ff.editing && !state_ff.edit_active, "commit left the session open")
   `DTSE_ASSERT_NEXT(a_load_opens, clock, reset, advance && in_word_ff.req_type == REQ_LOAD,
      state_ff.edit_active && state_ff.cursor == CURSOR_FIRST && rsp_valid_ff,
      "load did not open a session")

endmodule

`default_nettype wire

FILE: tb/date_time_setting_editor_checker.sv
// Checker for the date and time setting editor: watches both streams, predicts each
// result word from the request words and compares field by field.
// Depends on dtse_pkg for the request codes, cursor positions and word types.
`timescale 1ns / 1ps

module date_time_setting_editor_checker
   import dtse_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic [2:0]            req_tuser,
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic [1:0]            rsp_tuser,
   output int                    fail_count,
   output int                    pending,
   output int                    checked,
   output int                    commits
);

   localparam int PRINT_LIMIT = 30;

   logic         edit_on;
   logic [3:0]   cur;
   date_type     staged;
   date_type     stored;
   rsp_word_type shown_q[$];

   task automatic flag(input string msg);
      if (fail_count < PRINT_LIMIT) begin
         $display("ERROR @%0t: %s", $realtime, msg);
      end
      fail_count++;
   endtask

   task automatic check_field(input string name, input int got, input int want);
      if (got != want) begin
         flag($sformatf("result word %0d %s: got %0d, want %0d", checked, name, got, want));
      end
   endtask

   function automatic int days_in_month(input int y, input int m);
      if (m == 2) begin
         return ((y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0))) ? 29 : 28;
      end
      if (m == 4 || m == 6 || m == 9 || m == 11) begin
         return 30;
      end
      return 31;
   endfunction

   // past either end lands on the opposite end
   function automatic int roll(input int v, input int delta, input int lo, input int hi);
      int sum;
      sum = v + delta;
      if (sum > hi) begin
         return lo;
      end
      if (sum < lo) begin
         return hi;
      end
      return sum;
   endfunction

   function automatic void nudge(input int dir);
      int y;
      int mo;
      int d;
      int h;
      int mi;
      int s;
      int step;
      y = staged.year;
      mo = staged.month;
      d = staged.day;
      h = staged.hour;
      mi = staged.minute;
      s = staged.second;
      step = cur[0] ? 10 : 1;
      if (cur < POS_MONTH) begin
         case (cur - CURSOR_FIRST)
            0: step = 1000;
            1: step = 100;
            2: step = 10;
            default: step = 1;
         endcase
         y = y + dir * step;
         if (dir > 0 && y > int'(YEAR_MAX)) begin
            y = YEAR_MAX;
         end
         if (dir < 0 && y < int'(YEAR_MIN)) begin
            y = YEAR_MIN;
         end
      end else if (cur < POS_DAY) begin
         mo = roll(mo, dir * step, 1, 12);
      end else if (cur < POS_HOUR) begin
         d = roll(d, dir * step, 1, days_in_month(y, mo));
      end else if (cur < POS_MINUTE) begin
         h = roll(h, dir * step, 0, 23);
      end else if (cur < POS_SECOND) begin
         mi = roll(mi, dir * step, 0, 59);
      end else if (cur <= CURSOR_LAST) begin
         s = roll(s, dir * step, 0, 59);
      end
      staged.year = y[11:0];
      staged.month = mo[3:0];
      staged.day = d[4:0];
      staged.hour = h[4:0];
      staged.minute = mi[5:0];
      staged.second = s[5:0];
   endfunction

   function automatic rsp_word_type step_editor(input logic [2:0] code,
                                               input logic [REQ_DATA_W-1:0] data);
      rsp_word_type shown;
      date_type     view;
      logic         did_commit;
      did_commit = 1'b0;
      if (code == REQ_LOAD) begin
         staged.year = data[11:0];
         staged.month = data[15:12];
         staged.day = data[20:16];
         staged.hour = data[25:21];
         staged.minute = data[31:26];
         staged.second = data[37:32];
         cur = CURSOR_FIRST;
         edit_on = 1'b1;
      end else if (edit_on) begin
         case (code)
            REQ_INC: nudge(1);
            REQ_DEC: nudge(-1);
            REQ_LEFT: cur = (cur <= CURSOR_FIRST) ? CURSOR_LAST : cur - 4'd1;
            REQ_RIGHT: cur = (cur >= CURSOR_LAST) ? CURSOR_FIRST : cur + 4'd1;
            REQ_CONFIRM: begin
               stored = staged;
               edit_on = 1'b0;
               did_commit = 1'b1;
            end
            REQ_CANCEL: edit_on = 1'b0;
            default: ;
         endcase
      end
      view = edit_on ? staged : stored;
      shown.show_year = view.year;
      shown.show_month = view.month;
      shown.show_day = view.day;
      shown.show_hour = view.hour;
      shown.show_minute = view.minute;
      shown.show_second = view.second;
      shown.cursor_pos = edit_on ? cur : 4'd0;
      shown.committed = did_commit;
      shown.editing = edit_on;
      return shown;
   endfunction

   always @(posedge clock) begin
      rsp_word_type want;
      if (reset) begin
         edit_on = 1'b0;
         cur = CURSOR_FIRST;
         staged = DATE_RESET;
         stored = DATE_RESET;
         shown_q.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (shown_q.size() == 0) begin
               flag($sformatf("result word %0d with nothing expected", checked));
            end else begin
               want = shown_q.pop_front();
               check_field("show_year", rsp_tdata[11:0], want.show_year);
               check_field("show_month", rsp_tdata[15:12], want.show_month);
               check_field("show_day", rsp_tdata[20:16], want.show_day);
               check_field("show_hour", rsp_tdata[25:21], want.show_hour);
               check_field("show_minute", rsp_tdata[31:26], want.show_minute);
               check_field("show_second", rsp_tdata[37:32], want.show_second);
               check_field("cursor_pos", rsp_tdata[41:38], want.cursor_pos);
               check_field("committed", rsp_tuser[0], want.committed);
               check_field("editing", rsp_tuser[1], want.editing);
               if (want.committed) begin
                  commits++;
               end
            end
            checked++;
         end
         if (req_tvalid && req_tready) begin
            shown_q.push_back(step_editor(req_tuser, req_tdata));
         end
      end
      pending = shown_q.size();
   end

endmodule

FILE: tb/tb_top.sv
// Testbench top for the date and time setting editor: clock, reset, request and
// result stream drivers, watchdog and verdict.
// Depends on dtse_pkg, date_time_setting_editor and date_time_setting_editor_checker.
`timescale 1ns / 1ps

module tb_top;
   import dtse_pkg::*;

   localparam logic [2:0] REQ_UNUSED = 3'd7;
   localparam int WATCHDOG_LIMIT = 1000;
   localparam int LONG_HOLD = 80;
   localparam int ITEM_TARGET = 1350;
   localparam int CALM_AFTER = 1150;
   localparam int HOLD_AT = 400;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   // new_year, new_month, new_day, new_hour, new_minute, new_second, zero pad
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   // req_type
   logic [2:0]            req_tuser = REQ_LOAD;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   // show_year, show_month, show_day, show_hour, show_minute, show_second,
   // cursor_pos, zero pad
   logic [RSP_DATA_W-1:0] rsp_tdata;
   // committed, editing
   logic [1:0]            rsp_tuser;

   int fail_count;
   int pending;
   int checked;
   int commits;
   int sent = 0;
   int sessions = 0;
   int quiet = 0;
   bit idle_on = 1'b1;
   bit long_hold_req = 1'b0;
   bit hold_done = 1'b0;

   date_time_setting_editor dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

   date_time_setting_editor_checker checker_i (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser),
      .fail_count(fail_count),
      .pending   (pending),
      .checked   (checked),
      .commits   (commits)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [REQ_DATA_W-1:0] pack_req(input logic [11:0] y, input logic [3:0] mo,
                                                      input logic [4:0] d, input logic [4:0] h,
                                                      input logic [5:0] mi, input logic [5:0] s);
      return {2'b00, s, mi, h, d, mo, y};
   endfunction

   function automatic logic [REQ_DATA_W-1:0] noise_payload();
      return pack_req(12'($urandom), 4'($urandom), 5'($urandom), 5'($urandom),
                      6'($urandom), 6'($urandom));
   endfunction

   // mostly in-range dates, now and then raw bits
   function automatic logic [REQ_DATA_W-1:0] load_payload();
      if ($urandom_range(0, 99) < 15) begin
         return noise_payload();
      end
      return pack_req(12'($urandom_range(YEAR_MIN, YEAR_MAX)), 4'($urandom_range(1, 12)),
                      5'($urandom_range(1, 31)), 5'($urandom_range(0, 23)),
                      6'($urandom_range(0, 59)), 6'($urandom_range(0, 59)));
   endfunction

   // called and returns at a falling edge
   task automatic send_word(input logic [2:0] code, input logic [REQ_DATA_W-1:0] payload);
      int gap;
      if (idle_on && !long_hold_req && $urandom_range(0, 99) < 12) begin
         req_tvalid = 1'b0;
         gap = $urandom_range(1, 11);
         repeat (gap) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser = code;
      req_tdata = payload;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
      sent++;
      if (sent == HOLD_AT) begin
         long_hold_req = 1'b1;
      end
      if (sent >= CALM_AFTER) begin
         idle_on = 1'b0;
      end
   endtask

   task automatic run_session();
      int ops;
      int pick;
      sessions++;
      send_word(REQ_LOAD, load_payload());
      ops = $urandom_range(3, 30);
      repeat (ops) begin
         pick = $urandom_range(0, 99);
         if (pick < 30) begin
            send_word(REQ_INC, noise_payload());
         end else if (pick < 55) begin
            send_word(REQ_DEC, noise_payload());
         end else if (pick < 75) begin
            send_word(REQ_LEFT, noise_payload());
         end else begin
            send_word(REQ_RIGHT, noise_payload());
         end
      end
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
         send_word(REQ_CONFIRM, noise_payload());
      end else if (pick < 95) begin
         send_word(REQ_CANCEL, noise_payload());
      end
   endtask

   // result side: random back-pressure plus one long hold
   initial begin
      int burst;
      wait (!reset);
      forever begin
         @(negedge clock);
         if (long_hold_req && !hold_done) begin
            rsp_tready = 1'b0;
            repeat (LONG_HOLD) @(negedge clock);
            rsp_tready = 1'b1;
            hold_done = 1'b1;
            long_hold_req = 1'b0;
         end else if (idle_on && $urandom_range(0, 99) < 15) begin
            rsp_tready = 1'b0;
            burst = $urandom_range(1, 11);
            repeat (burst) @(negedge clock);
            rsp_tready = 1'b1;
         end else begin
            rsp_tready = 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet <= 0;
      end else if (quiet + 1 >= WATCHDOG_LIMIT) begin
         $display("watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
         $display("date_time_setting_editor regression: fail");
         $finish;
      end else begin
         quiet <= quiet + 1;
      end
   end

   initial begin
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // requests with no session open
      send_word(REQ_INC, noise_payload());
      send_word(REQ_CONFIRM, noise_payload());
      send_word(REQ_UNUSED, noise_payload());
      // lowest date, clamp and wrap at both ends
      send_word(REQ_LOAD, pack_req(YEAR_MIN, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0));
      send_word(REQ_DEC, noise_payload());
      send_word(REQ_LEFT, noise_payload());
      send_word(REQ_DEC, noise_payload());
      send_word(REQ_RIGHT, noise_payload());
      send_word(REQ_INC, noise_payload());
      send_word(REQ_CONFIRM, noise_payload());
      send_word(REQ_CANCEL, noise_payload());
      // leap day, load while editing
      send_word(REQ_LOAD, pack_req(12'd2099, 4'd12, 5'd31, 5'd23, 6'd59, 6'd59));
      send_word(REQ_LOAD, pack_req(12'd2000, 4'd2, 5'd29, 5'd23, 6'd59, 6'd59));
      repeat (POS_DAY) send_word(REQ_RIGHT, noise_payload());
      send_word(REQ_INC, noise_payload());
      send_word(REQ_DEC, noise_payload());
      // raw field values out of range
      send_word(REQ_LOAD, pack_req('1, '1, '1, '1, '1, '1));
      send_word(REQ_INC, noise_payload());
      send_word(REQ_LOAD, pack_req('0, '0, '0, '0, '0, '0));
      send_word(REQ_DEC, noise_payload());
      send_word(REQ_UNUSED, noise_payload());
      send_word(REQ_CANCEL, noise_payload());

      while (sent < ITEM_TARGET) begin
         if ($urandom_range(0, 99) < 15) begin
            send_word(3'($urandom_range(0, 7)), noise_payload());
         end else begin
            run_session();
         end
      end
      req_tvalid = 1'b0;
      idle_on = 1'b0;

      while (pending != 0) @(negedge clock);
      repeat (8) @(negedge clock);

      $display("sent %0d request words in %0d edit sessions, one long result stall",
               sent, sessions);
      $display("checked %0d result words, %0d commits seen", checked, commits);
      if (fail_count == 0 && pending == 0) begin
         $display("date_time_setting_editor regression: pass");
      end else begin
         $display("date_time_setting_editor regression: fail");
      end
      $finish;
   end

endmodule
